// ----- rtl/fbp_pkg.sv -----
`default_nettype none

package fbp_pkg;

  localparam int NUM_BINS    = 32;
  localparam int MAX_RESULTS = 32;

  localparam int IDX_W     = $clog2(NUM_BINS);
  localparam int SCAN_W    = $clog2(NUM_BINS + 1);
  localparam int RCNT_W    = $clog2(MAX_RESULTS + 1);
  localparam int SIZE_W    = 16;
  localparam int OUT_IDX_W = 5;

  localparam logic [15:0] CAP_RESET = 16'd50;

  localparam logic CMD_PLACE  = 1'b0;
  localparam logic CMD_REPORT = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_item;
    logic pipe_adv;
    logic place_commit;
    logic place_fail;
    logic rep_take;
    logic rep_flush;
  } fbp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic eval_vld;
    logic place_hit;
    logic rep_hit;
    logic scan_end;
    logic out_free;
    logic pend_vld;
  } fbp_stat_t;

  // The result carries the low OUT_IDX_W bits of the bin number, which with 32 bins is the whole number.
  function automatic logic [OUT_IDX_W-1:0] idx_to_out(input logic [IDX_W-1:0] idx);
    logic [IDX_W+OUT_IDX_W-1:0] wide;
    wide = {{OUT_IDX_W{1'b0}}, idx};
    return wide[OUT_IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/fbp_ram.sv -----
`default_nettype none

module fbp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fbp_ctrl.sv -----
`default_nettype none

module fbp_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  input  wire logic              in_command,
  output logic                   in_stall,
  input  wire fbp_pkg::fbp_stat_t stat,
  output fbp_pkg::fbp_cmd_t      cmd
);

  import fbp_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PLACE,
    ST_REPORT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.load_item = 1'b1;
          state_nxt     = (in_command == CMD_REPORT) ? ST_REPORT : ST_PLACE;
        end
      end
      ST_PLACE: begin
        if (stat.scan_end) begin
          if (stat.out_free) begin
            cmd.place_fail = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end else if (stat.eval_vld && stat.place_hit) begin
          // Hold the scan on the chosen bin until the result word can be loaded.
          if (stat.out_free) begin
            cmd.place_commit = 1'b1;
            state_nxt        = ST_IDLE;
          end
        end else begin
          cmd.pipe_adv = 1'b1;
        end
      end
      ST_REPORT: begin
        if (stat.scan_end) begin
          if (stat.out_free) begin
            cmd.rep_flush = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else if (stat.eval_vld && stat.rep_hit) begin
          if (!stat.pend_vld || stat.out_free) begin
            cmd.rep_take = 1'b1;
            cmd.pipe_adv = 1'b1;
          end
        end else begin
          cmd.pipe_adv = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/fbp_datapath.sv -----
`default_nettype none

module fbp_datapath (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_wr_en,
  input  wire logic [15:0]                      cfg_wr_data,
  input  wire logic [fbp_pkg::SIZE_W-1:0]       in_item_size,
  input  wire fbp_pkg::fbp_cmd_t                cmd,
  output fbp_pkg::fbp_stat_t                    stat,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [fbp_pkg::OUT_IDX_W-1:0]         out_bin_index,
  output logic [15:0]                           out_room_left,
  output logic                                  out_bin_now_full,
  output logic                                  out_no_room,
  output logic                                  out_none_to_report,
  output logic                                  out_last_result
);

  import fbp_pkg::*;

  localparam logic [SCAN_W-1:0] SCAN_LEN = SCAN_W'(NUM_BINS);
  localparam logic [RCNT_W-1:0] RCNT_MAX = RCNT_W'(MAX_RESULTS);

  logic [15:0]       cap_r;
  logic [SIZE_W-1:0] size_r;
  logic              used_r   [NUM_BINS];
  logic              closed_r [NUM_BINS];

  logic [SCAN_W-1:0] addr_r;
  logic [IDX_W-1:0]  eval_idx_r;
  logic              eval_vld_r;
  logic [RCNT_W-1:0] rcnt_r;

  logic              pend_vld_r;
  logic [IDX_W-1:0]  pend_idx_r;
  logic [15:0]       pend_room_r;

  logic              out_valid_r;
  logic [OUT_IDX_W-1:0] out_idx_r;
  logic [15:0]       out_room_r;
  logic              out_full_r;
  logic              out_noroom_r;
  logic              out_none_r;
  logic              out_last_r;

  logic [OUT_IDX_W-1:0] out_idx_nxt;
  logic [15:0]       out_room_nxt;
  logic              out_full_nxt;
  logic              out_noroom_nxt;
  logic              out_none_nxt;
  logic              out_last_nxt;
  logic              load_out;

  logic              rd_en;
  logic [15:0]       cur_room;
  logic              cur_used;
  logic              cur_closed;
  logic              oversize;
  logic [15:0]       new_room;
  logic              new_full;
  logic              out_free;

  fbp_ram #(
    .WIDTH (16),
    .DEPTH (NUM_BINS)
  ) u_room_ram (
    .clk     (clk),
    .wr_en   (cmd.place_commit),
    .wr_addr (eval_idx_r),
    .wr_data (new_room),
    .rd_en   (rd_en),
    .rd_addr (addr_r[IDX_W-1:0]),
    .rd_data (cur_room)
  );

  assign rd_en      = cmd.pipe_adv && (addr_r != SCAN_LEN);
  assign cur_used   = used_r[eval_idx_r];
  assign cur_closed = closed_r[eval_idx_r];
  assign oversize   = size_r > cap_r;
  assign out_free   = !out_valid_r || !out_stall;

  always_comb begin
    if (!cur_used) begin
      new_room = oversize ? 16'd0 : (cap_r - size_r);
      new_full = !oversize && (new_room == 16'd0);
    end else begin
      new_room = cur_room - size_r;
      new_full = (new_room == 16'd0);
    end
  end

  always_comb begin
    stat.eval_vld  = eval_vld_r;
    stat.place_hit = !cur_used ||
                     (!cur_closed && (cur_room != 16'd0) && (size_r <= cur_room));
    stat.rep_hit   = cur_used && !cur_closed && (cur_room != 16'd0) && (rcnt_r < RCNT_MAX);
    stat.scan_end  = !eval_vld_r && (addr_r == SCAN_LEN);
    stat.out_free  = out_free;
    stat.pend_vld  = pend_vld_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_wr_en) begin
      cap_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      size_r <= in_item_size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_BINS; i++) begin
        used_r[i]   <= 1'b0;
        closed_r[i] <= 1'b0;
      end
    end else if (cmd.place_commit) begin
      used_r[eval_idx_r]   <= 1'b1;
      closed_r[eval_idx_r] <= cur_used ? cur_closed : oversize;
    end
  end

  // Scan pipeline: addr_r is the bin being read, eval_idx_r the bin whose room is on rd_data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r     <= '0;
      eval_vld_r <= 1'b0;
      eval_idx_r <= '0;
    end else if (cmd.load_item) begin
      addr_r     <= '0;
      eval_vld_r <= 1'b0;
    end else if (cmd.pipe_adv) begin
      eval_vld_r <= rd_en;
      if (rd_en) begin
        eval_idx_r <= addr_r[IDX_W-1:0];
        addr_r     <= addr_r + SCAN_W'(1);
      end
    end
  end

  // A report keeps its newest hit pending, since only the end of the scan tells which is last.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_vld_r <= 1'b0;
      rcnt_r     <= '0;
    end else if (cmd.load_item) begin
      pend_vld_r <= 1'b0;
      rcnt_r     <= '0;
    end else if (cmd.rep_take) begin
      pend_vld_r <= 1'b1;
      rcnt_r     <= rcnt_r + RCNT_W'(1);
    end else if (cmd.rep_flush) begin
      pend_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rep_take) begin
      pend_idx_r  <= eval_idx_r;
      pend_room_r <= cur_room;
    end
  end

  always_comb begin
    out_idx_nxt    = '0;
    out_room_nxt   = '0;
    out_full_nxt   = 1'b0;
    out_noroom_nxt = 1'b0;
    out_none_nxt   = 1'b0;
    out_last_nxt   = 1'b1;
    load_out       = 1'b0;
    if (cmd.place_commit) begin
      load_out     = 1'b1;
      out_idx_nxt  = idx_to_out(eval_idx_r);
      out_room_nxt = new_room;
      out_full_nxt = new_full;
    end else if (cmd.place_fail) begin
      load_out       = 1'b1;
      out_noroom_nxt = 1'b1;
    end else if (cmd.rep_take && pend_vld_r) begin
      load_out     = 1'b1;
      out_idx_nxt  = idx_to_out(pend_idx_r);
      out_room_nxt = pend_room_r;
      out_last_nxt = 1'b0;
    end else if (cmd.rep_flush) begin
      load_out = 1'b1;
      if (pend_vld_r) begin
        out_idx_nxt  = idx_to_out(pend_idx_r);
        out_room_nxt = pend_room_r;
      end else begin
        out_none_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_idx_r    <= out_idx_nxt;
      out_room_r   <= out_room_nxt;
      out_full_r   <= out_full_nxt;
      out_noroom_r <= out_noroom_nxt;
      out_none_r   <= out_none_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_bin_index      = out_idx_r;
  assign out_room_left      = out_room_r;
  assign out_bin_now_full   = out_full_r;
  assign out_no_room        = out_noroom_r;
  assign out_none_to_report = out_none_r;
  assign out_last_result    = out_last_r;

endmodule

`default_nettype wire

// ----- rtl/first_fit_bin_packer.sv -----
// Channel  Handshake              Payload
// in       in_valid / in_stall    in_command, in_item_size
// out      out_valid / out_stall  out_bin_index, out_room_left, out_bin_now_full,
//                                 out_no_room, out_none_to_report, out_last_result
// cfg      cfg_wr_en              cfg_wr_data (bin capacity)
//
// Each word scans the bins in order through the room memory's single read port,
// one bin per cycle, except while a stalled output pauses the scan.
// One word is worked on at a time; in_stall is high from acceptance until the
// last result word is loaded into the output register.
// Reset (rst_n low, synchronous) marks every bin unused and sets the capacity to 50.
// A stalled output holds its word and pauses the scan when another result is due.
`default_nettype none

module first_fit_bin_packer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [15:0] in_item_size,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [4:0]       out_bin_index,
  output logic [15:0]      out_room_left,
  output logic             out_bin_now_full,
  output logic             out_no_room,
  output logic             out_none_to_report,
  output logic             out_last_result
);

  import fbp_pkg::*;

  fbp_cmd_t  cmd;
  fbp_stat_t stat;

  fbp_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  fbp_datapath u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_item_size       (in_item_size),
    .cmd                (cmd),
    .stat               (stat),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_bin_index      (out_bin_index),
    .out_room_left      (out_room_left),
    .out_bin_now_full   (out_bin_now_full),
    .out_no_room        (out_no_room),
    .out_none_to_report (out_none_to_report),
    .out_last_result    (out_last_result)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a word was accepted");

  a_noroom_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_no_room) |->
      (out_room_left == 16'd0 && !out_bin_now_full && out_last_result))
    else $error("no_room word carries stray fields");

  a_full_zero_room: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_bin_now_full) |-> (out_room_left == 16'd0))
    else $error("full bin reported with room left");

  a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_none_to_report) |-> (out_last_result && !out_no_room))
    else $error("empty report word is not the last word");
`endif

endmodule

`default_nettype wire

// ----- tb/first_fit_bin_packer_tb.sv -----
`default_nettype none

module first_fit_bin_packer_tb;
  import fbp_pkg::*;

  typedef struct packed {
    logic [4:0]  bin_index;
    logic [15:0] room_left;
    logic        bin_now_full;
    logic        no_room;
    logic        none_to_report;
    logic        last_result;
  } pack_result_t;

  // One row of the directed table: either a capacity write or a word to send,
  // the latter with an optional hand-written result.
  typedef struct {
    bit           is_cfg;
    logic         command;
    logic [15:0]  value;
    bit           typed;
    pack_result_t res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_command = CMD_PLACE;
  logic [15:0] in_item_size = 16'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  out_bin_index;
  logic [15:0] out_room_left;
  logic        out_bin_now_full;
  logic        out_no_room;
  logic        out_none_to_report;
  logic        out_last_result;

  // Predictor copy of the bin state and the capacity register.
  logic [15:0] capacity;
  logic [15:0] room_of [NUM_BINS];
  bit          opened [NUM_BINS];
  bit          sealed [NUM_BINS];

  pack_result_t results_due [$];
  dir_row_t     dir_rows [$];
  int           mismatch_count = 0;
  bit           jitter_on = 1'b0;
  int           stall_left = 0;

  first_fit_bin_packer DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_command        (in_command),
    .in_item_size      (in_item_size),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_bin_index     (out_bin_index),
    .out_room_left     (out_room_left),
    .out_bin_now_full  (out_bin_now_full),
    .out_no_room       (out_no_room),
    .out_none_to_report(out_none_to_report),
    .out_last_result   (out_last_result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic pack_result_t make_result(int idx, int room, bit full, bit nr,
                                               bit none, bit last);
    pack_result_t r;
    r.bin_index      = 5'(idx);
    r.room_left      = 16'(room);
    r.bin_now_full   = full;
    r.no_room        = nr;
    r.none_to_report = none;
    r.last_result    = last;
    return r;
  endfunction

  // First-fit placement or a listing of the open bins, appended to results_due.
  function automatic void predict_packing(logic command, logic [15:0] size);
    int  found;
    logic [15:0] left;
    found = 0;
    if (command == CMD_PLACE) begin
      for (int i = 0; i < NUM_BINS && found == 0; i++) begin
        if (!opened[i]) begin
          opened[i] = 1'b1;
          found = 1;
          if (size > capacity) begin
            // An oversized item takes a fresh bin to itself and seals it.
            room_of[i] = 16'd0;
            sealed[i] = 1'b1;
            results_due.push_back(make_result(i, 0, 0, 0, 0, 1));
          end else begin
            left = capacity - size;
            room_of[i] = left;
            sealed[i] = 1'b0;
            results_due.push_back(make_result(i, int'(left), left == 0, 0, 0, 1));
          end
        end else if (!sealed[i] && room_of[i] != 0 && size <= room_of[i]) begin
          found = 1;
          left = room_of[i] - size;
          room_of[i] = left;
          results_due.push_back(make_result(i, int'(left), left == 0, 0, 0, 1));
        end
      end
      if (found == 0)
        results_due.push_back(make_result(0, 0, 0, 1, 0, 1));
    end else begin
      for (int i = 0; i < NUM_BINS && found < MAX_RESULTS; i++) begin
        if (opened[i] && !sealed[i] && room_of[i] != 0) begin
          results_due.push_back(make_result(i, int'(room_of[i]), 0, 0, 0, 0));
          found++;
        end
      end
      if (found == 0)
        results_due.push_back(make_result(0, 0, 0, 0, 1, 1));
      else
        results_due[results_due.size() - 1].last_result = 1'b1;
    end
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  // Result checker and stall generator share the clock edge.
  always @(posedge clk) begin
    pack_result_t want;
    int r;
    if (rst_n && out_valid && !out_stall) begin
      if (results_due.size() == 0) begin
        $error("unexpected result word: bin_index %0d room_left %0d",
               out_bin_index, out_room_left);
        mismatch_count++;
      end else begin
        want = results_due.pop_front();
        check_field("bin_index", 32'(want.bin_index), 32'(out_bin_index));
        check_field("room_left", 32'(want.room_left), 32'(out_room_left));
        check_field("bin_now_full", 32'(want.bin_now_full), 32'(out_bin_now_full));
        check_field("no_room", 32'(want.no_room), 32'(out_no_room));
        check_field("none_to_report", 32'(want.none_to_report),
                    32'(out_none_to_report));
        check_field("last_result", 32'(want.last_result), 32'(out_last_result));
      end
    end
    if (!jitter_on) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        out_stall <= 1'b0;
      end else if (r < 95) begin
        stall_left = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        stall_left = $urandom_range(8, 40);
        out_stall <= 1'b1;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!jitter_on || r < 60)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [15:0] pick_size(logic [15:0] cap);
    int r;
    r = $urandom_range(0, 99);
    if (r < 10)
      return 16'd0;
    if (r < 20)
      return cap;
    if (r < 35)
      return (cap == 16'hFFFF) ? 16'hFFFF : 16'($urandom_range(int'(cap) + 1, 65535));
    if (r < 40)
      return 16'hFFFF;
    return 16'($urandom_range(1, int'(cap)));
  endfunction

  task automatic send_word(logic command, logic [15:0] size);
    int gap;
    in_valid     <= 1'b1;
    in_command   <= command;
    in_item_size <= size;
    do
      @(posedge clk);
    while (in_stall);
    predict_packing(command, size);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (results_due.size() != 0)
      @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_capacity(logic [15:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    capacity = value;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic add_row(bit is_cfg, logic command, int value, bit typed,
                         int idx, int room, bit full, bit nr, bit none, bit last);
    dir_row_t row;
    row.is_cfg  = is_cfg;
    row.command = command;
    row.value   = 16'(value);
    row.typed   = typed;
    row.res     = make_result(idx, room, full, nr, none, last);
    dir_rows.push_back(row);
  endtask

  initial begin
    logic [15:0] phase_cap [4];
    logic        command;

    capacity = CAP_RESET;
    for (int i = 0; i < NUM_BINS; i++) begin
      room_of[i] = 16'd0;
      opened[i]  = 1'b0;
      sealed[i]  = 1'b0;
    end

    // Capacity 50 after reset.
    add_row(0, CMD_REPORT, 0,     1, 0, 0,  0, 0, 1, 1);
    add_row(0, CMD_PLACE,  0,     1, 0, 50, 0, 0, 0, 1);
    add_row(0, CMD_PLACE,  50,    1, 0, 0,  1, 0, 0, 1);
    add_row(0, CMD_PLACE,  65535, 1, 1, 0,  0, 0, 0, 1);
    add_row(0, CMD_PLACE,  51,    1, 2, 0,  0, 0, 0, 1);
    add_row(0, CMD_PLACE,  20,    1, 3, 30, 0, 0, 0, 1);
    add_row(0, CMD_PLACE,  0,     1, 3, 30, 0, 0, 0, 1);
    add_row(0, CMD_REPORT, 0,     1, 3, 30, 0, 0, 0, 1);
    add_row(0, CMD_PLACE,  30,    1, 3, 0,  1, 0, 0, 1);
    add_row(0, CMD_PLACE,  10,    0, 0, 0,  0, 0, 0, 0);
    // Largest capacity: a full-size item fills a fresh bin exactly.
    add_row(1, CMD_PLACE,  65535, 0, 0, 0,  0, 0, 0, 0);
    add_row(0, CMD_PLACE,  65535, 1, 5, 0,  1, 0, 0, 1);
    add_row(0, CMD_PLACE,  1,     0, 0, 0,  0, 0, 0, 0);
    add_row(0, CMD_PLACE,  40000, 0, 0, 0,  0, 0, 0, 0);
    add_row(0, CMD_REPORT, 65535, 0, 0, 0,  0, 0, 0, 0);
    // Smallest capacity.
    add_row(1, CMD_PLACE,  1,     0, 0, 0,  0, 0, 0, 0);
    add_row(0, CMD_PLACE,  2,     0, 0, 0,  0, 0, 0, 0);
    add_row(0, CMD_PLACE,  30000, 0, 0, 0,  0, 0, 0, 0);
    add_row(0, CMD_PLACE,  1,     0, 0, 0,  0, 0, 0, 0);
    add_row(0, CMD_REPORT, 0,     0, 0, 0,  0, 0, 0, 0);

    repeat (3) @(posedge clk);
    rst_n     <= 1'b1;
    jitter_on <= 1'b1;

    foreach (dir_rows[k]) begin
      if (dir_rows[k].is_cfg) begin
        drain();
        write_capacity(dir_rows[k].value);
      end else begin
        send_word(dir_rows[k].command, dir_rows[k].value);
        // A hand-written result replaces the predicted one; the predictor
        // has still advanced its bin state.
        if (dir_rows[k].typed) begin
          void'(results_due.pop_back());
          results_due.push_back(dir_rows[k].res);
        end
      end
    end

    phase_cap[0] = 16'hFFFF;
    phase_cap[1] = 16'd1;
    phase_cap[2] = 16'($urandom_range(2, 200));
    phase_cap[3] = 16'($urandom_range(1, 65535));
    for (int p = 0; p < 4; p++) begin
      drain();
      jitter_on <= (p != 1);
      write_capacity(phase_cap[p]);
      for (int n = 0; n < 40; n++) begin
        command = ($urandom_range(0, 99) < 20) ? CMD_REPORT : CMD_PLACE;
        if (command == CMD_PLACE)
          send_word(command, pick_size(capacity));
        else
          send_word(command, 16'($urandom));
      end
    end

    drain();
    repeat (NUM_BINS + 8) @(posedge clk);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/fbp_pkg.sv
rtl/fbp_ram.sv
rtl/fbp_ctrl.sv
rtl/fbp_datapath.sv
rtl/first_fit_bin_packer.sv
tb/first_fit_bin_packer_tb.sv
